FILE: rtl/core/pdb_pkg.sv
// ----------------------------------------------------------------------------
// pdb_pkg
// shared widths, reset values, register indexes and types of the balancer
// ----------------------------------------------------------------------------
package pdb_pkg;

    // parameter defaults
    localparam int DUTY_MAX_DEF       = 1023;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int SUM_WIDTH_DEF      = 48;

    // fixed field widths
    localparam int GAIN_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int ERR_W      = COUNT_W + 1;
    localparam int DERIV_W    = ERR_W + 1;
    localparam int DUTY_W     = 10;
    localparam int CTRL_W     = 32;
    localparam int DRIVE_W    = CTRL_W + 2;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // integral product is held within +-2^62
    localparam int PROD_LIMIT_EXP = 62;

    // register reset values
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
    localparam logic [DUTY_W-1:0]        BASE_DUTY_RST  = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_DERIV_GAIN = 2'd1,
        REG_INTEG_GAIN = 2'd2,
        REG_BASE_DUTY  = 2'd3
    } cfg_reg_t;

    // h-bridge duty pair of one motor
    typedef struct packed {
        logic [DUTY_W-1:0] rev;
        logic [DUTY_W-1:0] fwd;
    } duty_pair_t;

endpackage

FILE: rtl/core/pdb_drive_split.sv
// ----------------------------------------------------------------------------
// pdb_drive_split
// clamps a signed motor drive and splits it into a forward/reverse duty pair
// ----------------------------------------------------------------------------
module pdb_drive_split #(
    parameter int DUTY_MAX = pdb_pkg::DUTY_MAX_DEF
) (
    input  logic signed [pdb_pkg::DRIVE_W-1:0] drive_i,
    output pdb_pkg::duty_pair_t                duty_o
);
    import pdb_pkg::*;

    localparam logic signed [DRIVE_W-1:0] LIMIT = DRIVE_W'(DUTY_MAX);

    logic signed [DRIVE_W-1:0] clamped;
    logic signed [DRIVE_W-1:0] magnitude;

    always_comb begin
        clamped = drive_i;
        if (drive_i > LIMIT) begin
            clamped = LIMIT;
        end else if (drive_i < -LIMIT) begin
            clamped = -LIMIT;
        end

        magnitude = clamped[DRIVE_W-1] ? -clamped : clamped;

        // zero drive leaves both channels off
        duty_o = '0;
        if (clamped[DRIVE_W-1]) begin
            duty_o.rev = magnitude[DUTY_W-1:0];
        end else if (clamped != '0) begin
            duty_o.fwd = magnitude[DUTY_W-1:0];
        end
    end

endmodule

FILE: rtl/core/pid_differential_drive_balancer.sv
// ----------------------------------------------------------------------------
// pid_differential_drive_balancer
// pid correction of a differential drive from summed wheel encoder counts
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one transfer per encoder sample, s_tdata holds the left and
//   right cumulative counts. m_ channel: one transfer per sample with the
//   four h-bridge duties and the correction u.
//   error e = left + right, derivative e - previous e, integral is a
//   saturating sum of e. u = (kp*e + kd*de + ki*sum) / 2^GAIN_FRAC_BITS,
//   truncated toward zero and saturated to 32 bits. left drive is base - u,
//   right drive is base + u, each clamped to +-DUTY_MAX. gains and base duty
//   come through the cfg_ write port, one register per write; the user must
//   change them only while the pipeline is empty; the block does not enforce it.
// timing
//   five register stages: input, state update, multiply, sum and scale,
//   output. a result passes them in that order on its way to m_, and one
//   item is taken every cycle while m_ is not stalled. the products of the
//   multiply stage are each registered before the final sum.
// reset and stall
//   aresetn (synchronous, active low) empties the pipeline, clears the
//   previous error and the integral and loads the register reset values.
//   each stage holds while the next one is full and stalled, so a stalled
//   receiver fills the pipeline before s_tready drops; bubbles collapse.
// ----------------------------------------------------------------------------
module pid_differential_drive_balancer #(
    parameter int DUTY_MAX       = pdb_pkg::DUTY_MAX_DEF,
    parameter int GAIN_FRAC_BITS = pdb_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SUM_WIDTH      = pdb_pkg::SUM_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // configuration write port
    input  logic                               cfg_we,
    input  logic [pdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdb_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    // encoder samples
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [2*pdb_pkg::COUNT_W-1:0]      s_tdata,  // left_count, right_count

    // drive results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [4*pdb_pkg::DUTY_W+pdb_pkg::CTRL_W-1:0] m_tdata
    // left_forward_duty, left_reverse_duty, right_forward_duty,
    // right_reverse_duty, control_value
);
    import pdb_pkg::*;

    localparam int PROP_W = GAIN_W + ERR_W;
    localparam int DPRD_W = GAIN_W + DERIV_W;
    localparam int PROD_W = GAIN_W + SUM_WIDTH;

    localparam logic [ACC_W-1:0] ROUND_BIAS =
        ACC_W'((65'd1 << GAIN_FRAC_BITS) - 65'd1);
    localparam logic signed [ACC_W-1:0] U_MAX = ACC_W'({1'b0, {(CTRL_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] U_MIN = ~U_MAX;

    // configuration registers
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] deriv_gain_reg;
    logic signed [GAIN_W-1:0] integ_gain_reg;
    logic [DUTY_W-1:0]        base_duty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            base_duty_reg  <= BASE_DUTY_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_wdata;
                REG_BASE_DUTY:  base_duty_reg  <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage handshake: a stage loads when it is empty or being drained
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;
    logic b_ready, c_ready, d_ready, e_ready;
    logic b_load;

    assign e_ready  = !m_valid_reg || m_tready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign s_tready = !a_valid_reg || b_ready;
    assign b_load   = a_valid_reg && b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_tready) a_valid_reg <= s_tvalid;
            if (b_ready)  b_valid_reg <= a_valid_reg;
            if (c_ready)  c_valid_reg <= b_valid_reg;
            if (d_ready)  d_valid_reg <= c_valid_reg;
            if (e_ready)  m_valid_reg <= d_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage a: error of the sample
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] a_err_reg;
    logic signed [ERR_W-1:0] a_err_next;

    assign a_err_next = ERR_W'($signed(s_tdata[COUNT_W-1:0]))
                      + ERR_W'($signed(s_tdata[2*COUNT_W-1:COUNT_W]));

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            a_err_reg <= a_err_next;
        end
    end

    // ------------------------------------------------------------------
    // stage b: derivative and saturating integral; the state registers
    // double as this stage's error and integral
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]     prev_error_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [DERIV_W-1:0]   b_deriv_reg;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] error_sum_next;
    logic signed [DERIV_W-1:0]   deriv_next;

    always_comb begin
        sum_wide   = (SUM_WIDTH+1)'(error_sum_reg) + (SUM_WIDTH+1)'(a_err_reg);
        deriv_next = DERIV_W'(a_err_reg) - DERIV_W'(prev_error_reg);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            // integral sticks at its rail
            error_sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                                 : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            error_sum_next = sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
        end else if (b_load) begin
            prev_error_reg <= a_err_reg;
            error_sum_reg  <= error_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_deriv_reg <= deriv_next;
        end
    end

    // ------------------------------------------------------------------
    // stage c: the three gain products
    // ------------------------------------------------------------------
    logic signed [PROP_W-1:0] prop_prod;
    logic signed [DPRD_W-1:0] deriv_prod;
    logic signed [PROD_W-1:0] integ_prod;
    logic signed [ACC_W-1:0]  integ_clamped;
    logic signed [PROP_W-1:0] c_prop_reg;
    logic signed [DPRD_W-1:0] c_deriv_reg;
    logic signed [ACC_W-1:0]  c_integ_reg;

    assign prop_prod  = PROP_W'(prop_gain_reg) * PROP_W'(prev_error_reg);
    assign deriv_prod = DPRD_W'(deriv_gain_reg) * DPRD_W'(b_deriv_reg);
    assign integ_prod = PROD_W'(integ_gain_reg) * PROD_W'(error_sum_reg);

    generate
        if (PROD_W > PROD_LIMIT_EXP + 1) begin : g_integ_clamp
            localparam logic signed [PROD_W-1:0] LIM_POS =
                {{(PROD_W-PROD_LIMIT_EXP-1){1'b0}}, 1'b1, {PROD_LIMIT_EXP{1'b0}}};
            localparam logic signed [PROD_W-1:0] LIM_NEG = -LIM_POS;

            assign integ_clamped = (integ_prod > LIM_POS) ? ACC_W'(LIM_POS)
                                 : (integ_prod < LIM_NEG) ? ACC_W'(LIM_NEG)
                                 : ACC_W'(integ_prod);
        end else begin : g_integ_plain
            // product cannot pass the limit at this width
            assign integ_clamped = ACC_W'(integ_prod);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            c_prop_reg  <= prop_prod;
            c_deriv_reg <= deriv_prod;
            c_integ_reg <= integ_clamped;
        end
    end

    // ------------------------------------------------------------------
    // stage d: sum, scale toward zero and saturate to 32 bits
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_adj;
    logic signed [ACC_W-1:0]  acc_quot;
    logic signed [CTRL_W-1:0] u_next;
    logic signed [CTRL_W-1:0] d_u_reg;

    always_comb begin
        acc_sum  = ACC_W'(c_prop_reg) + ACC_W'(c_deriv_reg) + c_integ_reg;
        // negative sums get the bias so the shift truncates toward zero
        acc_adj  = acc_sum + (acc_sum[ACC_W-1] ? ROUND_BIAS : '0);
        acc_quot = acc_adj >>> GAIN_FRAC_BITS;
        if (acc_quot > U_MAX) begin
            u_next = CTRL_W'(U_MAX);
        end else if (acc_quot < U_MIN) begin
            u_next = CTRL_W'(U_MIN);
        end else begin
            u_next = CTRL_W'(acc_quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && c_valid_reg) begin
            d_u_reg <= u_next;
        end
    end

    // ------------------------------------------------------------------
    // stage e: motor drives into the output register
    // ------------------------------------------------------------------
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
    logic signed [DRIVE_W-1:0] base_ext;
    duty_pair_t                duty_left;
    duty_pair_t                duty_right;
    duty_pair_t                m_left_reg;
    duty_pair_t                m_right_reg;
    logic signed [CTRL_W-1:0]  m_u_reg;

    assign base_ext    = DRIVE_W'(signed'({1'b0, base_duty_reg}));
    assign drive_left  = base_ext - DRIVE_W'(d_u_reg);
    assign drive_right = base_ext + DRIVE_W'(d_u_reg);

    pdb_drive_split #(
        .DUTY_MAX (DUTY_MAX)
    ) u_split_left (
        .drive_i (drive_left),
        .duty_o  (duty_left)
    );

    pdb_drive_split #(
        .DUTY_MAX (DUTY_MAX)
    ) u_split_right (
        .drive_i (drive_right),
        .duty_o  (duty_right)
    );

    always_ff @(posedge aclk) begin
        if (e_ready && d_valid_reg) begin
            m_left_reg  <= duty_left;
            m_right_reg <= duty_right;
            m_u_reg     <= d_u_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_u_reg, m_right_reg.rev, m_right_reg.fwd,
                       m_left_reg.rev, m_left_reg.fwd};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // input backpressure only when the whole pipeline is full behind a result
    a_ready_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready && d_valid_reg)
    ) else $error("input stalled while the pipeline has room");

    // a motor never drives both bridge channels
    a_left_exclusive: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_left_reg.fwd == '0 || m_left_reg.rev == '0)
    ) else $error("left forward and reverse both active");

    a_right_exclusive: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_right_reg.fwd == '0 || m_right_reg.rev == '0)
    ) else $error("right forward and reverse both active");

    // no correction means both motors get the same duties
    a_zero_u_balanced: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_u_reg == '0) |-> (m_left_reg == m_right_reg)
    ) else $error("unequal drives with zero correction");

    // controller state advances only with a sample entering stage b
    a_state_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !b_load |=> ($stable(prev_error_reg) && $stable(error_sum_reg))
    ) else $error("controller state changed without a sample");

endmodule
